>>> rtl/npst_pkg.sv
// ----------------------------------------------------------------------------
// npst_pkg: shared types and constants of the node pair set table
// Sizes, operation and status codes, and the structs that travel between
// the controller and the chain of storage cells.
// ----------------------------------------------------------------------------
package npst_pkg;

  // table size and derived widths
  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY);
  localparam int FILL_W   = $clog2(CAPACITY + 1);

  // request modes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_SORT   = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_PRESENT = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_RANGE   = 2'd3;

  // cell operations broadcast along the chain
  localparam logic [2:0] CELL_IDLE  = 3'd0;
  localparam logic [2:0] CELL_SCAN  = 3'd1;
  localparam logic [2:0] CELL_READ  = 3'd2;
  localparam logic [2:0] CELL_WRITE = 3'd3;
  localparam logic [2:0] CELL_CLEAR = 3'd4;
  localparam logic [2:0] CELL_SORT  = 3'd5;

  // one table entry; net is the major key, so a packed compare orders pairs
  typedef struct packed {
    logic [15:0] net;
    logic [15:0] node;
  } entry_t;

  // search/read result rippling toward cell 0
  typedef struct packed {
    logic   hit;
    entry_t ent;
  } carry_t;

  // broadcast control from the controller
  typedef struct packed {
    logic [2:0] op;
    entry_t     key;
  } cell_ctl_t;

  // per-cell position decode
  typedef struct packed {
    logic active;   // below fill count
    logic at_fill;  // next free slot
    logic rd_sel;   // addressed by read index
    logic lo_pair;  // lower member of a live compare pair this phase
    logic hi_pair;  // upper member of a live compare pair this phase
  } cell_sel_t;

endpackage

>>> rtl/npst_if.sv
// ----------------------------------------------------------------------------
// npst_if: request and result channels of the node pair set table
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface npst_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] net;
  logic [15:0] node;
  logic [5:0]  index;

  modport source (output valid, mode, net, node, index, input ready);
  modport sink   (input valid, mode, net, node, index, output ready);
endinterface

interface npst_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] read_net;
  logic [15:0] read_node;
  logic [6:0]  entry_count;

  modport source (output valid, status, read_net, read_node, entry_count, input ready);
  modport sink   (input valid, status, read_net, read_node, entry_count, output ready);
endinterface

>>> rtl/npst_cell.sv
// ----------------------------------------------------------------------------
// npst_cell: one storage cell of the table chain
// Holds one pair, swaps with a neighbor during sort phases, clears or loads
// itself on command, and forwards the search/read carry toward cell 0.
// ----------------------------------------------------------------------------
module npst_cell (
  input  logic               clk,
  input  npst_pkg::cell_ctl_t ctl,
  input  npst_pkg::cell_sel_t sel,
  input  npst_pkg::entry_t   left_ent,
  input  npst_pkg::entry_t   right_ent,
  input  npst_pkg::carry_t   carry_in,
  output npst_pkg::entry_t   ent,
  output npst_pkg::carry_t   carry_out
);
  import npst_pkg::*;

  entry_t ent_r, ent_nxt;
  carry_t carry_r, carry_nxt;
  logic   match;
  logic   own_hit;

  assign match = sel.active && (ent_r == ctl.key);

  // entry update
  always_comb begin
    ent_nxt = ent_r;
    case (ctl.op)
      CELL_WRITE: begin
        if (sel.at_fill) ent_nxt = ctl.key;
      end
      CELL_CLEAR: begin
        if (match) ent_nxt = '0;
      end
      CELL_SORT: begin
        // odd-even transposition: lower keeps the min, upper keeps the max
        if (sel.lo_pair && (right_ent < ent_r)) begin
          ent_nxt = right_ent;
        end else if (sel.hi_pair && (ent_r < left_ent)) begin
          ent_nxt = left_ent;
        end
      end
      default: ent_nxt = ent_r;
    endcase
  end

  // carry: own hit wins, otherwise pass the upstream carry along
  assign own_hit = (ctl.op == CELL_READ) ? (sel.rd_sel && sel.active) : match;

  always_comb begin
    carry_nxt     = carry_r;
    if ((ctl.op == CELL_SCAN) || (ctl.op == CELL_READ)) begin
      carry_nxt.hit = own_hit || carry_in.hit;
      carry_nxt.ent = own_hit ? ent_r : carry_in.ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r   <= ent_nxt;
    carry_r <= carry_nxt;
  end

  assign ent       = ent_r;
  assign carry_out = carry_r;

endmodule

>>> rtl/npst_ctrl.sv
// ----------------------------------------------------------------------------
// npst_ctrl: sequencer of the node pair set table
// Takes one request, runs the cell chain for a scan or sort pass (none for a
// remove), keeps the fill count and registers the result item.
// ----------------------------------------------------------------------------
module npst_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  npst_in_if.sink                     in_if,
  npst_out_if.source                  out_if,
  input  npst_pkg::carry_t            carry0,
  output npst_pkg::cell_ctl_t         ctl,
  output logic                        phase,
  output logic [npst_pkg::FILL_W-1:0] fill,
  output logic [5:0]                  idx
);
  import npst_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_SORT = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [1:0]        mode_r;
  entry_t            key_r;
  logic [5:0]        index_r;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        status_r, status_nxt;
  entry_t            rd_r, rd_nxt;

  logic              accept;
  logic              commit;
  logic              is_full;
  logic              in_range;
  logic              do_write;

  assign accept   = in_if.valid && in_if.ready;
  assign commit   = (state_r == S_FIN) && (!out_valid_r || out_if.ready);
  assign is_full  = (fill_r == FILL_W'(CAPACITY));
  assign in_range = (32'(index_r) < 32'(fill_r));
  assign do_write = (mode_r == MODE_INSERT) && !carry0.hit && !is_full;

  assign in_if.ready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cnt_nxt = CNT_W'(CAPACITY - 1);
          case (in_if.mode)
            MODE_REMOVE: state_nxt = S_FIN;
            MODE_SORT:   state_nxt = S_SORT;
            default:     state_nxt = S_SCAN;
          endcase
        end
      end
      S_SCAN, S_SORT: begin
        if (cnt_r == '0) state_nxt = S_FIN;
        else             cnt_nxt   = cnt_r - 1'b1;
      end
      S_FIN: begin
        if (commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // broadcast to the chain
  always_comb begin
    ctl.key = key_r;
    ctl.op  = CELL_IDLE;
    case (state_r)
      S_SCAN: ctl.op = (mode_r == MODE_READ) ? CELL_READ : CELL_SCAN;
      S_SORT: ctl.op = CELL_SORT;
      S_FIN: begin
        if (commit && do_write)                    ctl.op = CELL_WRITE;
        else if (commit && mode_r == MODE_REMOVE)  ctl.op = CELL_CLEAR;
      end
      default: ctl.op = CELL_IDLE;
    endcase
  end

  // result formation
  always_comb begin
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    status_nxt    = status_r;
    rd_nxt        = rd_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
      status_nxt    = STAT_DONE;
      rd_nxt        = '0;
      case (mode_r)
        MODE_INSERT: begin
          if (carry0.hit)   status_nxt = STAT_PRESENT;
          else if (is_full) status_nxt = STAT_FULL;
          else              fill_nxt   = fill_r + 1'b1;
        end
        MODE_READ: begin
          if (in_range) rd_nxt     = carry0.ent;
          else          status_nxt = STAT_RANGE;
        end
        default: status_nxt = STAT_DONE;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= in_if.mode;
      key_r    <= '{net: in_if.net, node: in_if.node};
      index_r  <= in_if.index;
    end
    status_r <= status_nxt;
    rd_r     <= rd_nxt;
  end

  // entry_count follows the live fill count, which only moves on commit
  assign out_if.valid       = out_valid_r;
  assign out_if.status      = status_r;
  assign out_if.read_net    = rd_r.net;
  assign out_if.read_node   = rd_r.node;
  assign out_if.entry_count = 7'(fill_r);

  assign phase = cnt_r[0];
  assign fill  = fill_r;
  assign idx   = index_r;

endmodule

>>> rtl/node_pair_set_table_unit.sv
// One request is handled at a time: a new request is taken only after the previous
// result has been committed. The search/read carry moves one cell per cycle along
// the chain, and the sort runs CAPACITY odd-even phases over the chain.
// Reset (synchronous, rst_n low) empties the table by clearing the fill count; no
// clearing pass runs and the cell contents are left as they are.
// ----------------------------------------------------------------------------
// node_pair_set_table_unit: bounded set of network/node address pairs
// Insert-if-absent, zero matching pairs, sort ascending and indexed read over
// a chain of storage cells driven by a small sequencer.
// ----------------------------------------------------------------------------
module node_pair_set_table_unit (
  input  logic       clk,
  input  logic       rst_n,
  npst_in_if.sink    in_if,
  npst_out_if.source out_if
);
  import npst_pkg::*;

  cell_ctl_t         ctl;
  logic              phase;
  logic [FILL_W-1:0] fill;
  logic [5:0]        idx;
  entry_t            ent   [CAPACITY];
  carry_t            carry [CAPACITY+1];

  npst_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .carry0 (carry[0]),
    .ctl    (ctl),
    .phase  (phase),
    .fill   (fill),
    .idx    (idx)
  );

  // nothing feeds the carry past the last cell
  assign carry[CAPACITY] = '0;

  // cell chain with per-position decode
  for (genvar i = 0; i < CAPACITY; i++) begin : g_chain
    localparam bit IS_ODD = (i % 2) == 1;
    localparam int LEFT   = (i == 0) ? 0 : i - 1;
    localparam int RIGHT  = (i == CAPACITY - 1) ? i : i + 1;
    cell_sel_t sel;

    always_comb begin
      sel.active  = 32'(fill) > i;
      sel.at_fill = 32'(fill) == i;
      sel.rd_sel  = 32'(idx) == i;
      sel.lo_pair = (IS_ODD == phase) && (32'(fill) > i + 1);
      sel.hi_pair = (IS_ODD != phase) && (i >= 1) && (32'(fill) > i);
    end

    npst_cell u_node (
      .clk       (clk),
      .ctl       (ctl),
      .sel       (sel),
      .left_ent  (ent[LEFT]),
      .right_ent (ent[RIGHT]),
      .carry_in  (carry[i+1]),
      .ent       (ent[i]),
      .carry_out (carry[i])
    );
  end

`ifndef SYNTHESIS
  // fill count stays within the table
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill) <= CAPACITY)
    else $error("fill count beyond capacity");

  // a full report only comes with a full table
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.status == STAT_FULL) |-> (32'(fill) == CAPACITY))
    else $error("full status with free slots");

  // out-of-range reads return zeros
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.status == STAT_RANGE)
      |-> (out_if.read_net == '0) && (out_if.read_node == '0))
    else $error("range status with read data");

  // one item in flight: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("request accepted while busy");
`endif

endmodule
